/* design/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CHECK_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("allocator check failed");
`define CHECK_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("allocator check failed");
`else
`define CHECK_SAME(label, clk, rst_n, cond, expr)
`define CHECK_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

/* design/scsa_pkg.sv */
// Shared types, codes and constants of the size-class slice allocator.
// Used by the allocator core and the testbench; depends on nothing else.
package scsa_pkg;

    localparam int NUM_CLASSES_DEF = 5;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int BLOCK_BYTES     = 128;
    localparam int BLOCK_SHIFT     = 7;
    localparam int SLICE_SHIFT     = 2;
    localparam int K_W             = 5;
    localparam logic [K_W-1:0] K_MAX = 5'd31;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_REGION_BASE   = 1'b0;
    localparam logic REG_REGION_BLOCKS = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_BAD_SIZE  = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_REFILL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        func;
        logic [6:0]  size_bytes;
        logic [31:0] slice_address;
    } req_t;

    typedef struct packed {
        logic [31:0] granted_address;
        status_t     status;
    } resp_t;

    // Number of significant bits of (size - 1) >> 2, which is the class index.
    function automatic logic [2:0] size_class(input logic [6:0] size);
        logic [6:0] dec;
        logic [4:0] v;
        logic [2:0] bits;
        dec  = size - 7'd1;
        v    = dec[6:2];
        bits = 3'd0;
        for (int i = 0; i < 5; i++)
        begin
            if (v[i])
            begin
                bits = 3'(i + 1);
            end
        end
        return bits;
    endfunction

endpackage

/* design/size_class_slice_allocator_core.sv */
// Top level of the size-class slice allocator: sequencer, counters and output register.
// Depends on scsa_pkg, scsa_stack_mem and assert_macros.svh.

// One request is taken at a time and its result word leaves through an output register,
// so a new request can be taken while the previous result still waits. A bad size, a
// free or an exhausted region goes from the execute state straight to the done state, a
// pop from a non-empty stack passes through the pop state to take the registered read
// data, and an allocate that carves a new block pushes its 128 / slice size - 1 spare
// slices in the refill state, one address per cycle into the stack memory's write port.
// After reset the stacks are empty and the block is ready at once.
`include "assert_macros.svh"

module size_class_slice_allocator_core
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output resp_t       out_word,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
    localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    state_t             state_reg, state_next;
    logic [31:0]        region_base_reg;
    logic [15:0]        region_blocks_reg;
    logic [15:0]        blocks_taken_reg, blocks_taken_next;
    logic [FILL_W-1:0]  fill_reg [NUM_CLASSES];
    logic [FILL_W-1:0]  fill_next [NUM_CLASSES];
    logic [FILL_W-1:0]  fill_cur;
    logic               func_reg, func_next;
    logic               bad_reg, bad_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [31:0]        addr_reg, addr_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    status_t            res_status_reg, res_status_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    resp_t              out_word_reg, out_word_next;
    logic [2:0]         cls_code;
    logic [MEM_AW-1:0]  cls_base;
    logic               mem_wr_en;
    logic [MEM_AW-1:0]  mem_wr_addr;
    logic [31:0]        mem_wr_data;
    logic               mem_rd_en;
    logic [MEM_AW-1:0]  mem_rd_addr;
    logic [31:0]        mem_rd_data;

    scsa_stack_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign fill_cur  = fill_reg[cls_reg];
    assign cls_code  = size_class(in_word.size_bytes);
    assign cls_base  = MEM_AW'(cls_reg) * MEM_AW'(STACK_DEPTH);

    always_comb
    begin
        state_next        = state_reg;
        blocks_taken_next = blocks_taken_reg;
        fill_next         = fill_reg;
        func_next         = func_reg;
        bad_next          = bad_reg;
        cls_next          = cls_reg;
        addr_next         = addr_reg;
        res_addr_next     = res_addr_reg;
        res_status_next   = res_status_reg;
        k_next            = k_reg;
        out_valid_next    = out_valid_reg;
        out_word_next     = out_word_reg;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = cls_base + MEM_AW'(fill_cur);
        mem_wr_data       = addr_reg;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = cls_base + MEM_AW'(fill_cur - FILL_W'(1));

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = in_word.func;
                    addr_next  = in_word.slice_address;
                    bad_next   = (in_word.size_bytes == 7'd0) ||
                                 (cls_code >= 3'(NUM_CLASSES));
                    cls_next   = CLS_W'(cls_code);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_addr_next   = 32'd0;
                res_status_next = STATUS_OK;
                state_next      = S_DONE;
                if (bad_reg)
                begin
                    res_status_next = STATUS_BAD_SIZE;
                end
                else if (func_reg == FUNC_FREE)
                begin
                    if (fill_cur >= FILL_W'(STACK_DEPTH))
                    begin
                        res_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        mem_wr_en          = 1'b1;
                        fill_next[cls_reg] = fill_cur + FILL_W'(1);
                    end
                end
                else if (fill_cur != '0)
                begin
                    mem_rd_en          = 1'b1;
                    fill_next[cls_reg] = fill_cur - FILL_W'(1);
                    state_next         = S_POP;
                end
                else if (blocks_taken_reg >= region_blocks_reg)
                begin
                    res_status_next = STATUS_EXHAUSTED;
                end
                else
                begin
                    res_addr_next     = region_base_reg + (32'(blocks_taken_reg) << BLOCK_SHIFT);
                    blocks_taken_next = blocks_taken_reg + 16'd1;
                    k_next            = K_MAX >> cls_reg;
                    state_next        = S_REFILL;
                end
            end
            S_POP:
            begin
                res_addr_next = mem_rd_data;
                state_next    = S_DONE;
            end
            S_REFILL:
            begin
                mem_wr_data = res_addr_reg + (32'(k_reg) << (3'(cls_reg) + 3'(SLICE_SHIFT)));
                if (fill_cur < FILL_W'(STACK_DEPTH))
                begin
                    mem_wr_en          = 1'b1;
                    fill_next[cls_reg] = fill_cur + FILL_W'(1);
                end
                k_next = k_reg - K_W'(1);
                if (k_reg == K_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_word_next.granted_address = res_addr_reg;
                    out_word_next.status          = res_status_reg;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            blocks_taken_reg  <= 16'd0;
            region_base_reg   <= 32'd0;
            region_blocks_reg <= 16'd0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            blocks_taken_reg <= blocks_taken_next;
            fill_reg         <= fill_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_REGION_BASE:   region_base_reg   <= cfg_wdata;
                    REG_REGION_BLOCKS: region_blocks_reg <= cfg_wdata[15:0];
                    default:           region_base_reg   <= region_base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        bad_reg        <= bad_next;
        cls_reg        <= cls_next;
        addr_reg       <= addr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        k_reg          <= k_next;
        out_word_reg   <= out_word_next;
    end

    // An accepted word always starts execution in the next cycle.
    `CHECK_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_reg == S_EXEC)
    // A stack count never runs past the stack depth while a valid request is at work.
    `CHECK_SAME(a_fill_bound, clk, rst_n, state_reg != S_IDLE && !bad_reg, fill_cur <= FILL_W'(STACK_DEPTH))
    // Only a successful allocate may return a nonzero address.
    `CHECK_SAME(a_err_zero, clk, rst_n, out_valid_reg && out_word_reg.status != STATUS_OK, out_word_reg.granted_address == 32'd0)
    // The pop state always follows the read issued during execution.
    `CHECK_SAME(a_pop_order, clk, rst_n, state_reg == S_POP, $past(state_reg) == S_EXEC)

endmodule

/* design/scsa_stack_mem.sv */
// Storage with one write port and one read port for the free-address stacks of all classes.
// Registered read data; no dependencies.
module scsa_stack_mem #(
    parameter int DEPTH = 320,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for size_class_slice_allocator_core: a queued request driver,
// a reply monitor and a built-in allocator predictor with randomized handshake idling.
// Depends on scsa_pkg and the design sources only.
module testbench
    import scsa_pkg::*;
();

    localparam int NUM_CLASSES = NUM_CLASSES_DEF;
    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 88;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    req_t        in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    resp_t       out_word;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_REGION_BASE;
    logic [31:0] cfg_wdata = '0;

    req_t        request_queue[$];
    resp_t       owed_replies[$];
    logic [31:0] slice_stack[NUM_CLASSES][STACK_DEPTH];
    int unsigned stack_count[NUM_CLASSES];
    logic [15:0] carved_blocks = '0;
    logic [31:0] pool_base = '0;
    logic [15:0] pool_blocks = '0;

    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    logic        no_idle = 1'b0;

    size_class_slice_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int class_for_size(logic [6:0] size);
        logic [4:0] v;
        int bits;
        if (size == 7'd0)
        begin
            return -1;
        end
        v = 5'((size - 7'd1) >> 2);
        bits = 0;
        while (v != 5'd0)
        begin
            bits++;
            v = v >> 1;
        end
        return (bits >= NUM_CLASSES) ? -1 : bits;
    endfunction

    function automatic void push_slice(int cls, logic [31:0] addr);
        if (stack_count[cls] < STACK_DEPTH)
        begin
            slice_stack[cls][stack_count[cls]] = addr;
            stack_count[cls]++;
        end
    endfunction

    function automatic void serve_request(req_t word);
        resp_t reply;
        int cls;
        int unsigned span;
        logic [31:0] block_addr;
        reply.granted_address = '0;
        reply.status = STATUS_OK;
        cls = class_for_size(word.size_bytes);
        if (cls < 0)
        begin
            reply.status = STATUS_BAD_SIZE;
        end
        else if (word.func == FUNC_FREE)
        begin
            if (stack_count[cls] >= STACK_DEPTH)
            begin
                reply.status = STATUS_FULL;
            end
            else
            begin
                push_slice(cls, word.slice_address);
            end
        end
        else if (stack_count[cls] != 0)
        begin
            stack_count[cls]--;
            reply.granted_address = slice_stack[cls][stack_count[cls]];
        end
        else if (carved_blocks >= pool_blocks)
        begin
            reply.status = STATUS_EXHAUSTED;
        end
        else
        begin
            span = 4 << cls;
            block_addr = pool_base + 32'(carved_blocks) * 32'(BLOCK_BYTES);
            carved_blocks++;
            reply.granted_address = block_addr;
            for (int k = BLOCK_BYTES / span; k > 1; k--)
            begin
                push_slice(cls, block_addr + 32'((k - 1) * span));
            end
        end
        owed_replies.push_back(reply);
    endfunction

    function automatic void check_reply(resp_t got);
        resp_t want;
        if (owed_replies.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("unexpected reply: address %h status %0d",
                         got.granted_address, got.status);
            end
        end
        else
        begin
            want = owed_replies.pop_front();
            if (got.granted_address !== want.granted_address || got.status !== want.status)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("reply mismatch: expected address %h status %0d, got %h %0d",
                             want.granted_address, want.status,
                             got.granted_address, got.status);
                end
            end
        end
    endfunction

    always @(posedge clk)
    begin : drive_proc
        req_t next_word;
        logic next_valid;
        next_word = in_word;
        next_valid = in_valid;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                serve_request(in_word);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (!no_idle && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 18) - 1;
                end
                else if (request_queue.size() > 0)
                begin
                    next_word = request_queue.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
        in_word <= next_word;
    end

    always @(posedge clk)
    begin : watch_proc
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_reply(out_word);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 18) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [6:0] size_in_class(int cls);
        int lo;
        lo = (cls == 0) ? 1 : (4 << (cls - 1)) + 1;
        return 7'($urandom_range(lo, 4 << cls));
    endfunction

    task automatic add_request(logic fn, logic [6:0] size, logic [31:0] addr);
        req_t word;
        word.func = fn;
        word.size_bytes = size;
        word.slice_address = addr;
        request_queue.push_back(word);
    endtask

    task automatic add_random_request(int alloc_pct, int focus);
        int roll;
        logic fn;
        logic [6:0] size;
        logic [31:0] addr;
        roll = $urandom_range(0, 99);
        fn = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
        if (roll < 5)
        begin
            size = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
        end
        else
        begin
            size = size_in_class((roll < 60) ? focus : $urandom_range(0, NUM_CLASSES - 1));
        end
        addr = $urandom();
        if (fn == FUNC_FREE && $urandom_range(0, 1) == 1)
        begin
            addr = pool_base + 32'($urandom_range(0, 4095) << 2);
        end
        add_request(fn, size, addr);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (request_queue.size() != 0 || in_valid || owed_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_REGION_BASE)
        begin
            pool_base = value;
        end
        else
        begin
            pool_blocks = value[15:0];
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] new_base;
        logic [15:0] new_blocks;
        int alloc_pct;
        int focus;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            stack_count[c] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With an empty region, allocation fails until something has been freed.
        add_request(FUNC_ALLOC, 7'd4, 32'h1234_5678);
        add_request(FUNC_FREE, 7'd0, 32'hDEAD_BEEF);
        add_request(FUNC_ALLOC, 7'd0, 32'h0);
        add_request(FUNC_ALLOC, 7'd65, 32'h0);
        add_request(FUNC_FREE, 7'd127, 32'hFFFF_FFFF);
        add_request(FUNC_FREE, 7'd1, 32'hFFFF_FFFF);
        add_request(FUNC_ALLOC, 7'd3, 32'hFFFF_FFFF);
        add_request(FUNC_FREE, 7'd64, 32'h0);
        add_request(FUNC_ALLOC, 7'd33, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(REG_REGION_BASE, 32'hFFFF_FF80);
        write_reg(REG_REGION_BLOCKS, 32'h0000_FFFF);
        @(negedge clk);

        // Refill each class from the top of the address space so carving wraps.
        add_request(FUNC_ALLOC, 7'd1, 32'h0);
        add_request(FUNC_ALLOC, 7'd5, 32'h0);
        add_request(FUNC_ALLOC, 7'd8, 32'h0);
        add_request(FUNC_ALLOC, 7'd9, 32'h0);
        add_request(FUNC_ALLOC, 7'd16, 32'h0);
        add_request(FUNC_ALLOC, 7'd17, 32'h0);
        add_request(FUNC_ALLOC, 7'd32, 32'h0);
        add_request(FUNC_ALLOC, 7'd33, 32'h0);
        add_request(FUNC_ALLOC, 7'd64, 32'h0);
        add_request(FUNC_ALLOC, 7'd64, 32'h0);
        add_request(FUNC_ALLOC, 7'd2, 32'h0);
        add_request(FUNC_FREE, 7'd20, 32'h8000_0004);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            new_base = 32'($urandom_range(0, 32'hFFFF_FF80));
            new_blocks = 16'($urandom_range(0, 16'hFFFF));
            alloc_pct = 50;
            focus = $urandom_range(0, NUM_CLASSES - 1);
            case (p)
                0:
                begin
                    new_base = 32'h0;
                    new_blocks = 16'h0;
                    alloc_pct = 60;
                    focus = 0;
                end
                1:
                begin
                    new_blocks = 16'hFFFF;
                    alloc_pct = 70;
                    focus = NUM_CLASSES - 1;
                end
                2:
                begin
                    new_blocks = carved_blocks + 16'($urandom_range(1, 4));
                    alloc_pct = 75;
                end
                3:
                begin
                    alloc_pct = 20;
                    focus = 0;
                end
                4:
                begin
                    new_blocks = carved_blocks + 16'd2;
                    alloc_pct = 25;
                    focus = 2;
                end
                default:
                begin
                    new_base = 32'hFFFF_FF80;
                    new_blocks = 16'hFFFF;
                end
            endcase
            write_reg(REG_REGION_BASE, new_base);
            write_reg(REG_REGION_BLOCKS, {16'h0, new_blocks});
            @(negedge clk);
            if (p == RANDOM_PHASES - 1)
            begin
                no_idle = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                add_random_request(alloc_pct, focus);
            end
        end

        wait_drained();
        if (fail_count == 0 && owed_replies.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/scsa_pkg.sv
design/scsa_stack_mem.sv
design/size_class_slice_allocator_core.sv
verif/testbench.sv
